### hdl/bsn_pkg.sv
// Package for the bitonic sort network: word width, default batch size
// and the sequencer state type. No dependencies.
package bsn_pkg;

	localparam int WORD_W         = 32;
	localparam int DEF_BATCH_SIZE = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_CMP,
		ST_WR_B,
		ST_EMIT
	} state_t;

endpackage

### hdl/bsn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/bitonic_sort_network.sv
// Bitonic sort network: loads a batch into a RAM, sorts it in place with one
// shared compare-exchange unit, then streams it out. Uses bsn_pkg and bsn_ram.
//
//  channel   signals                    handshake
//  ------    -------------------------  -----------------------------------
//  input     value                      taken when start is high, busy low
//  result    sorted_value, last_flag    valid for one cycle while strobe high
//
// Loading takes one word per cycle while start is high. The N-th word starts the
// sort: N/2 * log2(N)*(log2(N)+1)/2 compare-exchanges, each via the single RAM
// read port in ST_RD_A, ST_RD_B and ST_CMP, plus ST_WR_B for the second write
// on a swap. Emission reads N words, one per cycle, each shown in the cycle after
// its read. busy is high from the sort through the last read; reset drops a
// partial batch. The receiver cannot stall; results come out back to back.
module bitonic_sort_network #(
	parameter int BATCH_SIZE = bsn_pkg::DEF_BATCH_SIZE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [bsn_pkg::WORD_W-1:0] value,
	output logic                       strobe,
	output logic [bsn_pkg::WORD_W-1:0] sorted_value,
	output logic                       last_flag
);

	localparam int AW    = $clog2(BATCH_SIZE);
	localparam int LOG2N = AW;
	localparam int KW    = $clog2(LOG2N + 1);
	localparam int JW    = (LOG2N > 1) ? $clog2(LOG2N) : 1;

	localparam logic [AW-1:0] LAST_IDX  = AW'(BATCH_SIZE - 1);
	localparam logic [AW-1:0] LAST_PAIR = AW'(BATCH_SIZE / 2 - 1);
	localparam logic [KW-1:0] LAST_K    = KW'(LOG2N);

	bsn_pkg::state_t state_q, state_d;

	logic [AW-1:0] load_q;
	logic [AW-1:0] pair_q;
	logic [AW-1:0] emit_q;
	logic [KW-1:0] kexp_q;
	logic [JW-1:0] jexp_q;
	logic [bsn_pkg::WORD_W-1:0] x_q;
	logic          strobe_s1;
	logic          last_s1;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [bsn_pkg::WORD_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [bsn_pkg::WORD_W-1:0] ram_rdata;

	logic [AW-1:0] pair_dist;
	logic [AW-1:0] low_mask;
	logic [AW-1:0] lo_idx;
	logic [AW-1:0] hi_idx;
	logic [AW:0]   lo_wide;
	logic          descending;
	logic          swap;
	logic          pass_done;

	bsn_ram #(
		.WIDTH(bsn_pkg::WORD_W),
		.DEPTH(BATCH_SIZE)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The pair counter gets a zero bit inserted at the distance bit, which
	// yields the lower index of every pair whose partner lies above it.
	always_comb begin
		pair_dist  = AW'(1) << jexp_q;
		low_mask   = pair_dist - AW'(1);
		lo_idx     = AW'(((pair_q & ~low_mask) << 1) | (pair_q & low_mask));
		hi_idx     = lo_idx ^ pair_dist;
		lo_wide    = {1'b0, lo_idx};
		descending = lo_wide[kexp_q];
		swap       = descending ? (x_q < ram_rdata) : (x_q > ram_rdata);
		pass_done  = (pair_q == LAST_PAIR) && (jexp_q == '0) && (kexp_q == LAST_K);
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = load_q;
		ram_wdata = value;
		ram_raddr = lo_idx;
		unique case (state_q)
			bsn_pkg::ST_IDLE: begin
				if (start) begin
					ram_we = 1'b1;
					if (load_q == LAST_IDX) begin
						state_d = bsn_pkg::ST_RD_A;
					end
				end
			end
			bsn_pkg::ST_RD_A: begin
				ram_raddr = lo_idx;
				state_d   = bsn_pkg::ST_RD_B;
			end
			bsn_pkg::ST_RD_B: begin
				ram_raddr = hi_idx;
				state_d   = bsn_pkg::ST_CMP;
			end
			bsn_pkg::ST_CMP: begin
				if (swap) begin
					ram_we    = 1'b1;
					ram_waddr = lo_idx;
					ram_wdata = ram_rdata;
					state_d   = bsn_pkg::ST_WR_B;
				end else if (pass_done) begin
					state_d = bsn_pkg::ST_EMIT;
				end else begin
					state_d = bsn_pkg::ST_RD_A;
				end
			end
			bsn_pkg::ST_WR_B: begin
				ram_we    = 1'b1;
				ram_waddr = hi_idx;
				ram_wdata = x_q;
				state_d   = pass_done ? bsn_pkg::ST_EMIT : bsn_pkg::ST_RD_A;
			end
			bsn_pkg::ST_EMIT: begin
				ram_raddr = emit_q;
				if (emit_q == LAST_IDX) begin
					state_d = bsn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsn_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Load, schedule and emit counters, and the registered strobe and last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q    <= '0;
			pair_q    <= '0;
			emit_q    <= '0;
			kexp_q    <= KW'(1);
			jexp_q    <= '0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			strobe_s1 <= (state_q == bsn_pkg::ST_EMIT);
			last_s1   <= (state_q == bsn_pkg::ST_EMIT) && (emit_q == LAST_IDX);
			if (state_q == bsn_pkg::ST_IDLE && start) begin
				load_q <= (load_q == LAST_IDX) ? '0 : load_q + AW'(1);
				pair_q <= '0;
				emit_q <= '0;
				kexp_q <= KW'(1);
				jexp_q <= '0;
			end
			// The exchange of the current pair finishes here: step the schedule.
			if ((state_q == bsn_pkg::ST_CMP && !swap) || state_q == bsn_pkg::ST_WR_B) begin
				if (pair_q != LAST_PAIR) begin
					pair_q <= pair_q + AW'(1);
				end else begin
					pair_q <= '0;
					if (jexp_q != '0) begin
						jexp_q <= jexp_q - JW'(1);
					end else if (kexp_q != LAST_K) begin
						jexp_q <= JW'(kexp_q);
						kexp_q <= kexp_q + KW'(1);
					end
				end
			end
			if (state_q == bsn_pkg::ST_EMIT) begin
				emit_q <= emit_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bsn_pkg::ST_RD_B) begin
			x_q <= ram_rdata;
		end
	end

	assign busy         = (state_q != bsn_pkg::ST_IDLE);
	assign strobe       = strobe_s1;
	assign last_flag    = last_s1;
	assign sorted_value = ram_rdata;

endmodule

### sim/testbench.sv
// Self-checking bench for bitonic_sort_network: loads batches of words, predicts
// the sorted stream with its own compare-exchange network and checks each word.
// Depends on bsn_pkg and the RTL of bitonic_sort_network.

typedef struct {
	logic [bsn_pkg::WORD_W-1:0] word;
	logic                       last;
} sorted_word_t;

class batch_checker;
	logic [bsn_pkg::WORD_W-1:0] loaded_words[$];
	sorted_word_t               sorted_words[$];
	int                         errors;
	int                         words_taken;
	int                         words_checked;
	int                         batches_sorted;

	function new();
		errors         = 0;
		words_taken    = 0;
		words_checked  = 0;
		batches_sorted = 0;
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Same pairing schedule as the hardware: merge size doubles, distance halves,
	// and the bit of the lower index selected by k picks the direction.
	function void sort_batch();
		logic [bsn_pkg::WORD_W-1:0] buf_w[bsn_pkg::DEF_BATCH_SIZE];
		logic [bsn_pkg::WORD_W-1:0] tmp;
		sorted_word_t               sw;
		int                         k;
		int                         j;
		int                         p;
		int                         n;
		n = bsn_pkg::DEF_BATCH_SIZE;
		for (int i = 0; i < n; i++) buf_w[i] = loaded_words[i];
		for (k = 2; k <= n; k = k * 2) begin
			for (j = k / 2; j > 0; j = j / 2) begin
				for (int i = 0; i < n; i++) begin
					p = i ^ j;
					if (p > i && p < n) begin
						if (((i & k) != 0) ? (buf_w[i] < buf_w[p]) : (buf_w[i] > buf_w[p])) begin
							tmp      = buf_w[i];
							buf_w[i] = buf_w[p];
							buf_w[p] = tmp;
						end
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			sw.word = buf_w[i];
			sw.last = (i == n - 1);
			sorted_words.push_back(sw);
		end
		loaded_words.delete();
		batches_sorted++;
	endfunction

	function void take_word(logic [bsn_pkg::WORD_W-1:0] w);
		loaded_words.push_back(w);
		words_taken++;
		if (loaded_words.size() == bsn_pkg::DEF_BATCH_SIZE)
			sort_batch();
	endfunction

	task check_word(logic [bsn_pkg::WORD_W-1:0] w, logic last);
		sorted_word_t exp_w;
		if (sorted_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word %h last=%b", w, last));
		end else begin
			exp_w = sorted_words.pop_front();
			words_checked++;
			if (w !== exp_w.word)
				report_mismatch($sformatf("sorted_value %h, expected %h", w, exp_w.word));
			if (last !== exp_w.last)
				report_mismatch($sformatf("last_flag %b, expected %b", last, exp_w.last));
		end
	endtask

	function int pending();
		return sorted_words.size();
	endfunction
endclass

module testbench;
	localparam int N          = bsn_pkg::DEF_BATCH_SIZE;
	localparam int N_BATCHES  = 16;
	localparam int MAX_CYCLES = 200000;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [bsn_pkg::WORD_W-1:0] value;
	logic                       strobe;
	logic [bsn_pkg::WORD_W-1:0] sorted_value;
	logic                       last_flag;

	batch_checker sb;
	int           cycle_count = 0;
	bit           no_gaps;

	bitonic_sort_network #(.BATCH_SIZE(N)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.last_flag    (last_flag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			sb.check_word(sorted_value, last_flag);
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task send_word(logic [bsn_pkg::WORD_W-1:0] w);
		start <= 1'b1;
		value <= w;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		sb.take_word(w);
		@(negedge clk);
	endtask

	function int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Lowers start for the gap and, if asked, until every sorted word is out.
	task pause(int gap, bit drain);
		if (drain && gap == 0) gap = 1;
		if (gap > 0) begin
			start <= 1'b0;
			value <= $urandom;
			repeat (gap) @(negedge clk);
			while (drain && sb.pending() != 0) @(negedge clk);
		end
	endtask

	initial begin
		logic [bsn_pkg::WORD_W-1:0] directed[N];
		logic [bsn_pkg::WORD_W-1:0] w;
		logic [bsn_pkg::WORD_W-1:0] base;
		int                         shape;

		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		no_gaps = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Extremes, single bits at both ends, alternating patterns and equal words.
		directed = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'hA5A5_A5A5,
			32'h5A5A_5A5A, 32'h1234_5678, 32'h1234_5678, 32'h0000_0000,
			32'h0000_0001, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000};
		for (int i = 0; i < N; i++) send_word(directed[i]);
		pause(1, 1'b1);

		for (int b = 0; b < N_BATCHES; b++) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			shape   = $urandom_range(0, 5);
			base    = $urandom;
			for (int i = 0; i < N; i++) begin
				case (shape)
					0, 1:    w = $urandom;
					2:       w = $urandom_range(0, 7) | (base & 32'hFFFF_0000);
					3:       w = base + i * ($urandom_range(0, 3));
					4:       w = base - i * ($urandom_range(1, 1000));
					default: w = base;
				endcase
				send_word(w);
				pause(pick_gap(), (i == N - 1) && (b % 5 == 2));
			end
		end

		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("summary: %0d words loaded, %0d batches sorted, %0d sorted words checked",
			sb.words_taken, sb.batches_sorted, sb.words_checked);
		$display("summary: %0d mismatches in %0d cycles", sb.errors, cycle_count);
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
